// ----- src/psp_pkg.sv -----
// Shared widths, selection codes, register indexes and payload types for the segment distance block.
`default_nettype none

package psp_pkg;

    localparam int COORD_W = 32;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int QUOT_W  = 32;
    localparam int STEP_W  = DIFF_W + QUOT_W;
    localparam int SQ_W    = PROD_W;
    localparam int ROOT_W  = SQ_W / 2;
    localparam int SCALE_W = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [1:0] SEL_INNER = 2'd0;
    localparam logic [1:0] SEL_START = 2'd1;
    localparam logic [1:0] SEL_END   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_START_X      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_Y      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_Z      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_END_X        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_END_Y        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_END_Z        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH_SCALE = 3'd6;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t px;
        coord_t py;
        coord_t pz;
        logic   clamp;
    } query_t;

    typedef struct packed {
        coord_t nx;
        coord_t ny;
        coord_t nz;
        logic   outside;
        logic   err;
    } result_t;

    typedef struct packed {
        coord_t sx;
        coord_t sy;
        coord_t sz;
        coord_t ex;
        coord_t ey;
        coord_t ez;
    } seg_cfg_t;

    function automatic logic signed [DIFF_W-1:0] sext(coord_t v);
        return {v[COORD_W-1], v};
    endfunction

endpackage

`default_nettype wire

// ----- src/psp_dot.sv -----
// Three-stage pipeline forming the exact dot products dot(seg, p - start) and dot(seg, seg).
`default_nettype none

module psp_dot (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire psp_pkg::query_t                     in_query,
    input  wire psp_pkg::seg_cfg_t                   seg_cfg,
    output logic                                     out_valid,
    output psp_pkg::query_t                          out_query,
    output logic signed [psp_pkg::DOT_W-1:0]         dp,
    output logic signed [psp_pkg::DOT_W-1:0]         ss
);

    logic signed [psp_pkg::DIFF_W-1:0] seg_next [3];
    logic signed [psp_pkg::DIFF_W-1:0] rel_next [3];
    logic signed [psp_pkg::DIFF_W-1:0] seg_reg  [3];
    logic signed [psp_pkg::DIFF_W-1:0] rel_reg  [3];
    logic signed [psp_pkg::PROD_W-1:0] dp_prod_reg [3];
    logic signed [psp_pkg::PROD_W-1:0] ss_prod_reg [3];
    logic signed [psp_pkg::DOT_W-1:0]  dp_reg;
    logic signed [psp_pkg::DOT_W-1:0]  ss_reg;
    psp_pkg::query_t q1_reg, q2_reg, q3_reg;
    logic v1_reg, v2_reg, v3_reg;

    always_comb
    begin
        seg_next[0] = psp_pkg::sext(seg_cfg.ex) - psp_pkg::sext(seg_cfg.sx);
        seg_next[1] = psp_pkg::sext(seg_cfg.ey) - psp_pkg::sext(seg_cfg.sy);
        seg_next[2] = psp_pkg::sext(seg_cfg.ez) - psp_pkg::sext(seg_cfg.sz);
        rel_next[0] = psp_pkg::sext(in_query.px) - psp_pkg::sext(seg_cfg.sx);
        rel_next[1] = psp_pkg::sext(in_query.py) - psp_pkg::sext(seg_cfg.sy);
        rel_next[2] = psp_pkg::sext(in_query.pz) - psp_pkg::sext(seg_cfg.sz);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                seg_reg[i]     <= seg_next[i];
                rel_reg[i]     <= rel_next[i];
                dp_prod_reg[i] <= seg_reg[i] * rel_reg[i];
                ss_prod_reg[i] <= seg_reg[i] * seg_reg[i];
            end
            dp_reg <= psp_pkg::DOT_W'(dp_prod_reg[0]) + psp_pkg::DOT_W'(dp_prod_reg[1])
                    + psp_pkg::DOT_W'(dp_prod_reg[2]);
            ss_reg <= psp_pkg::DOT_W'(ss_prod_reg[0]) + psp_pkg::DOT_W'(ss_prod_reg[1])
                    + psp_pkg::DOT_W'(ss_prod_reg[2]);
            q1_reg <= in_query;
            q2_reg <= q1_reg;
            q3_reg <= q2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_query = q3_reg;
    assign dp        = dp_reg;
    assign ss        = ss_reg;

endmodule

`default_nettype wire

// ----- src/psp_div.sv -----
// Classification stage and pipelined restoring divider, one quotient bit per stage, for t = dp/ss.
`default_nettype none

module psp_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire psp_pkg::query_t                     in_query,
    input  wire logic signed [psp_pkg::DOT_W-1:0]    dp,
    input  wire logic signed [psp_pkg::DOT_W-1:0]    ss,
    output logic                                     out_valid,
    output psp_pkg::query_t                          out_query,
    output logic [1:0]                               sel,
    output logic [psp_pkg::QUOT_W-1:0]               t
);

    localparam int N = psp_pkg::QUOT_W;

    logic                          v_reg   [0:N];
    logic [1:0]                    sel_reg [0:N];
    logic [psp_pkg::DOT_W-1:0]     rem_reg [0:N];
    logic [psp_pkg::DOT_W-1:0]     div_reg [0:N];
    logic [N-1:0]                  q_reg   [0:N];
    psp_pkg::query_t               qry_reg [0:N];
    logic [1:0]                    sel_next;

    // Projection at or before the start, at or beyond the end, or strictly inside.
    always_comb
    begin
        if (dp[psp_pkg::DOT_W-1] || dp == '0)
            sel_next = psp_pkg::SEL_START;
        else if (ss <= dp)
            sel_next = psp_pkg::SEL_END;
        else
            sel_next = psp_pkg::SEL_INNER;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg[0] <= 1'b0;
        else if (adv)
            v_reg[0] <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sel_reg[0] <= sel_next;
            rem_reg[0] <= dp;
            div_reg[0] <= ss;
            q_reg[0]   <= '0;
            qry_reg[0] <= in_query;
        end
    end

    for (genvar k = 1; k <= N; k++)
    begin : g_stage
        logic [psp_pkg::DOT_W:0] shifted;
        logic [psp_pkg::DOT_W:0] diff;
        logic                    take;

        always_comb
        begin
            shifted = {rem_reg[k-1], 1'b0};
            diff    = shifted - {1'b0, div_reg[k-1]};
            take    = shifted >= {1'b0, div_reg[k-1]};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_reg[k-1];
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k] <= take ? diff[psp_pkg::DOT_W-1:0] : shifted[psp_pkg::DOT_W-1:0];
                q_reg[k]   <= {q_reg[k-1][N-2:0], take};
                div_reg[k] <= div_reg[k-1];
                sel_reg[k] <= sel_reg[k-1];
                qry_reg[k] <= qry_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_query = qry_reg[N];
    assign sel       = sel_reg[N];
    assign t         = q_reg[N];

endmodule

`default_nettype wire

// ----- src/psp_near.sv -----
// Nearest point from t and the segment, then squared distance to the query point, four stages.
`default_nettype none

module psp_near (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire psp_pkg::query_t                     in_query,
    input  wire logic [1:0]                          sel,
    input  wire logic [psp_pkg::QUOT_W-1:0]          t,
    input  wire psp_pkg::seg_cfg_t                   seg_cfg,
    output logic                                     out_valid,
    output psp_pkg::result_t                         out_res,
    output logic [psp_pkg::SQ_W-1:0]                 sq_sum
);

    localparam int CW = psp_pkg::COORD_W;
    localparam int DW = psp_pkg::DIFF_W;
    localparam int SW = psp_pkg::STEP_W;
    localparam int QW = psp_pkg::SQ_W - 1;

    psp_pkg::coord_t   s_vec [3];
    psp_pkg::coord_t   e_vec [3];
    psp_pkg::coord_t   p_vec [3];
    logic signed [DW-1:0] seg   [3];
    logic [DW-1:0]     mag      [3];
    logic [SW-1:0]     prod_reg [3];
    logic              neg_reg  [3];
    logic [1:0]        sel1_reg;
    psp_pkg::query_t   q1_reg, q2_reg;
    logic              v1_reg, v2_reg, v3_reg, v4_reg;

    psp_pkg::coord_t   near_next [3];
    psp_pkg::coord_t   near_reg  [3];
    logic              outside2_reg, err2_reg;
    logic [DW-1:0]     step [3];

    logic signed [DW-1:0]              delta [3];
    logic signed [psp_pkg::PROD_W-1:0] dsq   [3];
    logic [QW-1:0]     sq_reg [3];
    psp_pkg::result_t  r3_reg, r4_reg;
    logic [psp_pkg::SQ_W-1:0] sum_reg;

    always_comb
    begin
        s_vec[0] = seg_cfg.sx;
        s_vec[1] = seg_cfg.sy;
        s_vec[2] = seg_cfg.sz;
        e_vec[0] = seg_cfg.ex;
        e_vec[1] = seg_cfg.ey;
        e_vec[2] = seg_cfg.ez;
        p_vec[0] = q2_reg.px;
        p_vec[1] = q2_reg.py;
        p_vec[2] = q2_reg.pz;
        for (int i = 0; i < 3; i++)
        begin
            seg[i]  = psp_pkg::sext(e_vec[i]) - psp_pkg::sext(s_vec[i]);
            mag[i]  = seg[i][DW-1] ? DW'(-seg[i]) : DW'(seg[i]);
            step[i] = prod_reg[i][SW-1:psp_pkg::QUOT_W];
            unique case (sel1_reg)
                psp_pkg::SEL_INNER:
                    near_next[i] = neg_reg[i]
                        ? CW'({s_vec[i][CW-1], s_vec[i]} - step[i])
                        : CW'({s_vec[i][CW-1], s_vec[i]} + step[i]);
                psp_pkg::SEL_END:
                    near_next[i] = e_vec[i];
                default:
                    near_next[i] = s_vec[i];
            endcase
            delta[i] = psp_pkg::sext(p_vec[i]) - psp_pkg::sext(near_reg[i]);
            dsq[i]   = delta[i] * delta[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                prod_reg[i] <= SW'(mag[i]) * SW'(t);
                neg_reg[i]  <= seg[i][DW-1];
                near_reg[i] <= near_next[i];
                sq_reg[i]   <= dsq[i][QW-1:0];
            end
            sel1_reg     <= sel;
            q1_reg       <= in_query;
            q2_reg       <= q1_reg;
            outside2_reg <= (sel1_reg != psp_pkg::SEL_INNER);
            err2_reg     <= (sel1_reg != psp_pkg::SEL_INNER) && !q1_reg.clamp;
            r3_reg       <= '{nx: near_reg[0], ny: near_reg[1], nz: near_reg[2],
                              outside: outside2_reg, err: err2_reg};
            r4_reg       <= r3_reg;
            sum_reg      <= psp_pkg::SQ_W'(sq_reg[0]) + psp_pkg::SQ_W'(sq_reg[1])
                          + psp_pkg::SQ_W'(sq_reg[2]);
        end
    end

    assign out_valid = v4_reg;
    assign out_res   = r4_reg;
    assign sq_sum    = sum_reg;

endmodule

`default_nettype wire

// ----- src/psp_sqrt.sv -----
// Pipelined digit-by-digit integer square root, one root bit per stage.
`default_nettype none

module psp_sqrt (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                adv,
    input  wire logic                                in_valid,
    input  wire psp_pkg::result_t                    in_res,
    input  wire logic [psp_pkg::SQ_W-1:0]            value,
    output logic                                     out_valid,
    output psp_pkg::result_t                         out_res,
    output logic [psp_pkg::ROOT_W-1:0]               root
);

    localparam int N  = psp_pkg::ROOT_W;
    localparam int XW = psp_pkg::SQ_W;
    localparam int RW = N + 3;

    logic             v_reg    [1:N];
    logic [XW-1:0]    x_reg    [1:N];
    logic [RW-1:0]    rem_reg  [1:N];
    logic [N-1:0]     root_reg [1:N];
    psp_pkg::result_t res_reg  [1:N];

    for (genvar k = 1; k <= N; k++)
    begin : g_stage
        logic             v_prev;
        logic [XW-1:0]    x_prev;
        logic [RW-1:0]    rem_prev;
        logic [N-1:0]     root_prev;
        psp_pkg::result_t res_prev;
        logic [RW+1:0]    acc;
        logic [RW+1:0]    trial;
        logic [RW+1:0]    diff;
        logic             take;

        if (k == 1)
        begin : g_first
            assign v_prev    = in_valid;
            assign x_prev    = value;
            assign rem_prev  = '0;
            assign root_prev = '0;
            assign res_prev  = in_res;
        end
        else
        begin : g_rest
            assign v_prev    = v_reg[k-1];
            assign x_prev    = x_reg[k-1];
            assign rem_prev  = rem_reg[k-1];
            assign root_prev = root_reg[k-1];
            assign res_prev  = res_reg[k-1];
        end

        always_comb
        begin
            acc   = {rem_prev, x_prev[XW-1:XW-2]};
            trial = {{(RW-N){1'b0}}, root_prev, 2'b01};
            diff  = acc - trial;
            take  = acc >= trial;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                v_reg[k] <= 1'b0;
            else if (adv)
                v_reg[k] <= v_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                x_reg[k]    <= {x_prev[XW-3:0], 2'b00};
                rem_reg[k]  <= take ? diff[RW-1:0] : acc[RW-1:0];
                root_reg[k] <= {root_prev[N-2:0], take};
                res_reg[k]  <= res_prev;
            end
        end
    end

    assign out_valid = v_reg[N];
    assign out_res   = res_reg[N];
    assign root      = root_reg[N];

endmodule

`default_nettype wire

// ----- src/point_segment_projection_distance.sv -----
// Top level of the point to segment projection and distance block.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------------------------
//  cfg     | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//  in      | in        | in_valid/in_stall  | point_x, point_y, point_z, clamp_to_ends
//  out     | out       | out_valid/out_stall| near_x/y/z, scaled_distance, outside, proj_err
//
//  One query transaction is accepted every cycle while in_stall is low; each result passes through
//  3 dot-product stages, 33 divider stages, 4 nearest-point stages, 33 square-root
//  stages and 2 scaling stages. The one-bit-per-stage divider and root set most of the depth.
//  Reset clears every valid bit; the segment registers return to (0,0,0)-(1,0,0), scale 1.0.
//  While the output register holds a transaction that is stalled, the whole pipeline
//  freezes and in_stall is raised, so nothing is lost or repeated.
//  Configuration writes are always taken (cfg_ready is tied high).
`default_nettype none

module point_segment_projection_distance #(
    parameter int DIMENSIONS = 3
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [psp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [31:0]                       cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic signed [31:0]                point_x,
    input  wire logic signed [31:0]                point_y,
    input  wire logic signed [31:0]                point_z,
    input  wire logic                              clamp_to_ends,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic signed [31:0]                     near_x,
    output logic signed [31:0]                     near_y,
    output logic signed [31:0]                     near_z,
    output logic [31:0]                            scaled_distance,
    output logic                                   outside,
    output logic                                   projection_error
);

    // In two dimensions the z coordinates are treated as zero throughout.
    localparam logic USE_Z = (DIMENSIONS >= 3);
    localparam int   PW    = psp_pkg::ROOT_W + psp_pkg::SCALE_W;
    localparam int   FRAC  = 16;

    psp_pkg::coord_t start_x_reg, start_y_reg, start_z_reg;
    psp_pkg::coord_t end_x_reg, end_y_reg, end_z_reg;
    logic [psp_pkg::SCALE_W-1:0] scale_reg;

    psp_pkg::seg_cfg_t seg_cfg;
    psp_pkg::query_t   in_query;
    logic              adv;

    logic                               dot_valid;
    psp_pkg::query_t                    dot_query;
    logic signed [psp_pkg::DOT_W-1:0]   dot_dp, dot_ss;

    logic                               div_valid;
    psp_pkg::query_t                    div_query;
    logic [1:0]                         div_sel;
    logic [psp_pkg::QUOT_W-1:0]         div_t;

    logic                               near_valid;
    psp_pkg::result_t                   near_res;
    logic [psp_pkg::SQ_W-1:0]           near_sq;

    logic                               sq_valid;
    psp_pkg::result_t                   sq_res;
    logic [psp_pkg::ROOT_W-1:0]         sq_root;

    logic                               sc_valid_reg;
    psp_pkg::result_t                   sc_res_reg;
    logic [PW-1:0]                      sc_prod_reg;

    logic                               out_valid_reg;
    psp_pkg::result_t                   out_res_reg;
    logic [31:0]                        out_dist_reg;
    logic [31:0]                        dist_next;

    // Configuration registers; an index past the list is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg <= '0;
            start_y_reg <= '0;
            start_z_reg <= '0;
            end_x_reg   <= 32'sh0001_0000;
            end_y_reg   <= '0;
            end_z_reg   <= '0;
            scale_reg   <= 32'h0001_0000;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                psp_pkg::REG_START_X:      start_x_reg <= cfg_data;
                psp_pkg::REG_START_Y:      start_y_reg <= cfg_data;
                psp_pkg::REG_START_Z:      start_z_reg <= cfg_data;
                psp_pkg::REG_END_X:        end_x_reg   <= cfg_data;
                psp_pkg::REG_END_Y:        end_y_reg   <= cfg_data;
                psp_pkg::REG_END_Z:        end_z_reg   <= cfg_data;
                psp_pkg::REG_LENGTH_SCALE: scale_reg   <= cfg_data;
                default:                   ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    always_comb
    begin
        seg_cfg.sx = start_x_reg;
        seg_cfg.sy = start_y_reg;
        seg_cfg.sz = USE_Z ? start_z_reg : '0;
        seg_cfg.ex = end_x_reg;
        seg_cfg.ey = end_y_reg;
        seg_cfg.ez = USE_Z ? end_z_reg : '0;
        in_query.px    = point_x;
        in_query.py    = point_y;
        in_query.pz    = USE_Z ? point_z : '0;
        in_query.clamp = clamp_to_ends;
    end

    // The pipeline moves unless a finished transaction sits stalled in the output register.
    assign adv      = !(out_valid_reg && out_stall);
    assign in_stall = !adv;

    psp_dot u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (in_valid),
        .in_query  (in_query),
        .seg_cfg   (seg_cfg),
        .out_valid (dot_valid),
        .out_query (dot_query),
        .dp        (dot_dp),
        .ss        (dot_ss)
    );

    psp_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (dot_valid),
        .in_query  (dot_query),
        .dp        (dot_dp),
        .ss        (dot_ss),
        .out_valid (div_valid),
        .out_query (div_query),
        .sel       (div_sel),
        .t         (div_t)
    );

    psp_near u_near (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (div_valid),
        .in_query  (div_query),
        .sel       (div_sel),
        .t         (div_t),
        .seg_cfg   (seg_cfg),
        .out_valid (near_valid),
        .out_res   (near_res),
        .sq_sum    (near_sq)
    );

    psp_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (near_valid),
        .in_res    (near_res),
        .value     (near_sq),
        .out_valid (sq_valid),
        .out_res   (sq_res),
        .root      (sq_root)
    );

    // Scale the Q16.16 distance by the Q16.16 length scale and saturate to 32 bits.
    always_comb
    begin
        if (|sc_prod_reg[PW-1:FRAC+32])
            dist_next = '1;
        else
            dist_next = sc_prod_reg[FRAC+31:FRAC];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sc_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            sc_valid_reg  <= sq_valid;
            out_valid_reg <= sc_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sc_prod_reg  <= PW'(sq_root) * PW'(scale_reg);
            sc_res_reg   <= sq_res;
            out_res_reg  <= sc_res_reg;
            out_dist_reg <= dist_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign near_x           = out_res_reg.nx;
    assign near_y           = out_res_reg.ny;
    assign near_z           = out_res_reg.nz;
    assign scaled_distance  = out_dist_reg;
    assign outside          = out_res_reg.outside;
    assign projection_error = out_res_reg.err;

    // An error is only ever raised for a projection outside the segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outside || !projection_error))
        else $error("projection_error without outside");

    // An oversized product must leave the scaling stage as the saturated value.
    assert property (@(posedge clk) disable iff (!rst_n)
        (sc_valid_reg && adv && (|sc_prod_reg[PW-1:FRAC+32])) |=> (scaled_distance == '1))
        else $error("scaled distance did not saturate");

    // A frozen pipeline keeps its in-flight transactions in place.
    assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> ($stable(sq_valid) && $stable(div_valid) && $stable(sc_valid_reg)))
        else $error("pipeline moved while frozen");

endmodule

`default_nettype wire
